FILE: hdl/mcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcc_pkg;

  // Fixed widths of the port fields
  localparam int NUM_ATTR_PORTS  = 8;
  localparam int ATTR_PORT_BITS  = 4;
  localparam int SLOT_PORT_BITS  = 6;
  localparam int LEVEL_PORT_BITS = 3;
  localparam int COUNT_BITS      = 4;

  // Scratch width for zero-extending a field before trimming it to a parameter width
  localparam int WIDE_BITS = 8;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 4'd8;

  // Command codes
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // Control from the sequencer to the match unit
  typedef struct packed {
    logic clear;  // latch a new point, zero the running result
    logic take;   // fold the clause word on the read port into the result
  } acc_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/monotone_clause_classifier.sv
// Monotone clause classifier.
// Input channel (in_valid/in_ready) carries one word: cmd, slot_index,
// clause_level and attr_0..attr_7. A load word (cmd 0) writes one clause
// slot in the cycle it is accepted; the next word can follow at once.
// A classify word (cmd 1) scans every clause slot through the single read
// port of the clause memory, one slot per cycle, and returns one result
// word (point_class, any_match) on the output channel (out_valid/out_ready).
// out_valid rises when the result is loaded in S_DONE after S_SCAN and
// S_TAIL, and in_ready comes back in the same cycle as the result is loaded,
// as the sequencer returns to S_IDLE; the slot scan sets a classify's length.
// The result sits in an output register: while it waits, load words and a
// further classify are still taken; that next classify holds at the end of
// its scan until the receiver takes the waiting result.
// attribute_count is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle: the block does not enforce it. After reset
// the block sweeps the clause memory to mark every slot empty, with in_ready
// low meanwhile; attribute_count returns to 8 and any pending result is dropped.
`timescale 1ns / 1ps
`default_nettype none

module monotone_clause_classifier
  import mcc_pkg::*;
#(
  parameter int MAX_ATTRS    = 8,
  parameter int ATTR_BITS    = 4,
  parameter int CLAUSE_SLOTS = 64,
  parameter int CLASS_BITS   = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [COUNT_BITS-1:0]      cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       cmd,
  input  wire logic [SLOT_PORT_BITS-1:0]  slot_index,
  input  wire logic [LEVEL_PORT_BITS-1:0] clause_level,
  input  wire logic [ATTR_PORT_BITS-1:0]  attr_0,
  input  wire logic [ATTR_PORT_BITS-1:0]  attr_1,
  input  wire logic [ATTR_PORT_BITS-1:0]  attr_2,
  input  wire logic [ATTR_PORT_BITS-1:0]  attr_3,
  input  wire logic [ATTR_PORT_BITS-1:0]  attr_4,
  input  wire logic [ATTR_PORT_BITS-1:0]  attr_5,
  input  wire logic [ATTR_PORT_BITS-1:0]  attr_6,
  input  wire logic [ATTR_PORT_BITS-1:0]  attr_7,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [LEVEL_PORT_BITS-1:0]      point_class,
  output logic                            any_match
);

  localparam int AW        = (CLAUSE_SLOTS > 1) ? $clog2(CLAUSE_SLOTS) : 1;
  localparam int MIN_BITS  = MAX_ATTRS * ATTR_BITS;
  localparam int WORD_BITS = MIN_BITS + CLASS_BITS;
  localparam logic [AW-1:0] LAST_SLOT = AW'(CLAUSE_SLOTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_TAIL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                   state;
  logic [AW-1:0]            cnt;
  logic                     rd_valid;
  logic [COUNT_BITS-1:0]    attribute_count;

  logic [ATTR_PORT_BITS-1:0] attr_in [NUM_ATTR_PORTS];
  logic [MIN_BITS-1:0]      attr_vec;
  logic [CLASS_BITS-1:0]    level;
  logic [31:0]              slot_wide;
  logic                     slot_ok;
  logic                     in_acc;
  logic                     out_load;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [WORD_BITS-1:0]     wr_data;
  logic [WORD_BITS-1:0]     rd_data;
  logic                     rd_en;

  acc_ctl_t                 ctl;
  logic [CLASS_BITS-1:0]    best;
  logic                     hit;
  logic [WIDE_BITS-1:0]     best_wide;

  assign attr_in = '{attr_0, attr_1, attr_2, attr_3, attr_4, attr_5, attr_6, attr_7};

  // trim the port fields to the stored widths
  always_comb begin
    logic [WIDE_BITS-1:0] ext;
    logic [WIDE_BITS-1:0] lvl_ext;
    ext     = '0;
    lvl_ext = WIDE_BITS'(clause_level);
    for (int a = 0; a < MAX_ATTRS; a++) begin
      ext = WIDE_BITS'(attr_in[a]);
      attr_vec[a*ATTR_BITS +: ATTR_BITS] = ext[ATTR_BITS-1:0];
    end
    level = lvl_ext[CLASS_BITS-1:0];
  end

  assign slot_wide = 32'(slot_index);
  assign slot_ok   = slot_wide < 32'(CLAUSE_SLOTS);

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // memory write: clearing sweep or a load word
  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = '0;
    end else begin
      wr_en   = in_acc && (cmd == CMD_LOAD) && slot_ok;
      wr_addr = slot_wide[AW-1:0];
      wr_data = {level, attr_vec};
    end
  end

  assign rd_en = (state == S_SCAN);

  mcc_clause_mem #(
    .DEPTH (CLAUSE_SLOTS),
    .AW    (AW),
    .WIDTH (WORD_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  assign ctl.clear = in_acc && (cmd == CMD_CLASSIFY);
  assign ctl.take  = rd_valid;

  mcc_match_unit #(
    .MAX_ATTRS  (MAX_ATTRS),
    .ATTR_BITS  (ATTR_BITS),
    .CLASS_BITS (CLASS_BITS)
  ) u_match (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .point_in   (attr_vec),
    .attr_count (attribute_count),
    .word       (rd_data),
    .best       (best),
    .hit        (hit)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_count <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      attribute_count <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_SCAN);
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (in_acc && (cmd == CMD_CLASSIFY)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_SLOT) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          // last slot word is folded in this cycle
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
          cnt   <= '0;
        end
      endcase
    end
  end

  assign best_wide = WIDE_BITS'(best);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      point_class <= best_wide[LEVEL_PORT_BITS-1:0];
      any_match   <= hit;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcc_clause_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module mcc_clause_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int WIDTH = 35
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // one registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcc_match_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module mcc_match_unit
  import mcc_pkg::*;
#(
  parameter int MAX_ATTRS  = 8,
  parameter int ATTR_BITS  = 4,
  parameter int CLASS_BITS = 3
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire acc_ctl_t                                ctl,
  input  wire logic [MAX_ATTRS*ATTR_BITS-1:0]          point_in,
  input  wire logic [COUNT_BITS-1:0]                   attr_count,
  input  wire logic [MAX_ATTRS*ATTR_BITS+CLASS_BITS-1:0] word,
  output logic      [CLASS_BITS-1:0]                   best,
  output logic                                         hit
);

  localparam int MIN_BITS = MAX_ATTRS * ATTR_BITS;

  logic [MIN_BITS-1:0]   point;
  logic [CLASS_BITS-1:0] word_class;
  logic [MAX_ATTRS-1:0]  attr_ok;
  logic                  dominated;

  assign word_class = word[MIN_BITS +: CLASS_BITS];

  // per-attribute compare; attributes at or past the count always pass
  always_comb begin
    for (int a = 0; a < MAX_ATTRS; a++) begin
      attr_ok[a] = (COUNT_BITS'(a) >= attr_count) ||
                   (point[a*ATTR_BITS +: ATTR_BITS] >= word[a*ATTR_BITS +: ATTR_BITS]);
    end
  end

  // class zero marks an empty slot
  assign dominated = (&attr_ok) && (word_class != '0);

  // point latch
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      point <= point_in;
    end
  end

  // running maximum and match flag
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best <= '0;
      hit  <= 1'b0;
    end else if (ctl.take && dominated) begin
      hit <= 1'b1;
      if (word_class > best) begin
        best <= word_class;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mcc_checker
  import mcc_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       cmd,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [LEVEL_PORT_BITS-1:0] point_class,
  input wire logic                       any_match
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_class) && $stable(any_match))
    else $error("result word changed while stalled");

  // no match means class zero
  a_class_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> any_match || (point_class == '0))
    else $error("nonzero class without a match");

  // a classify word starts a scan; input closes
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_CLASSIFY) |=> !in_ready)
    else $error("input open right after classify");

  // a load word leaves the input open
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_LOAD) |=> in_ready)
    else $error("input closed after load");

  // the clearing sweep follows reset
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block open right after reset");

endmodule

bind monotone_clause_classifier mcc_checker u_mcc_checker (.*);

`default_nettype wire
